[design/bqd_pkg.sv]
// Package for the biquad section: microcode types, register indexes and the control program.
`default_nettype none

package bqd_pkg;

    // Wide datapath: products, accumulator and delay registers.
    localparam int ACC_W    = 64;
    localparam int NUM_REGS = 5;
    localparam int STEP_W   = 3;

    // Coefficient select; also the register index on the configuration port.
    typedef enum logic [2:0] {
        COEF_B0 = 3'd0,
        COEF_B1 = 3'd1,
        COEF_B2 = 3'd2,
        COEF_A1 = 3'd3,
        COEF_A2 = 3'd4
    } coef_sel_t;

    typedef enum logic {
        MS_X = 1'b0,
        MS_Y = 1'b1
    } mul_src_t;

    typedef enum logic {
        AA_PROD = 1'b0,
        AA_ACC  = 1'b1
    } alu_a_t;

    typedef enum logic [1:0] {
        AB_ZERO = 2'd0,
        AB_D1   = 2'd1,
        AB_D2   = 2'd2,
        AB_PROD = 2'd3
    } alu_b_t;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [1:0] {
        DST_NONE = 2'd0,
        DST_ACC  = 2'd1,
        DST_D1   = 2'd2,
        DST_D2   = 2'd3
    } alu_dst_t;

    // SQ_END returns to step zero once the output register can take the result.
    typedef enum logic {
        SQ_NEXT = 1'b0,
        SQ_END  = 1'b1
    } seq_t;

    typedef struct packed {
        logic      mul_en;
        coef_sel_t coef_sel;
        mul_src_t  mul_src;
        alu_a_t    alu_a;
        alu_b_t    alu_b;
        alu_op_t   alu_op;
        alu_dst_t  alu_dst;
        logic      y_load;
        seq_t      seq;
    } ctrl_word_t;

    // What the sequencer hands to the datapath each cycle.
    typedef struct packed {
        ctrl_word_t cw;
        logic       run;
        logic       start;
    } dp_ctrl_t;

    localparam ctrl_word_t CW_IDLE = '{
        mul_en:   1'b0,
        coef_sel: COEF_B0,
        mul_src:  MS_X,
        alu_a:    AA_PROD,
        alu_b:    AB_ZERO,
        alu_op:   OP_ADD,
        alu_dst:  DST_NONE,
        y_load:   1'b0,
        seq:      SQ_NEXT
    };

    // The filter program. The product register is written one step and read the next.
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = CW_IDLE;
        case (step)
            3'd0:
            begin
                // prod = b0 * x
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_B0;
                cw.mul_src  = MS_X;
            end
            3'd1:
            begin
                // acc = prod + d1, prod = b1 * x
                cw.alu_a    = AA_PROD;
                cw.alu_b    = AB_D1;
                cw.alu_dst  = DST_ACC;
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_B1;
                cw.mul_src  = MS_X;
            end
            3'd2:
            begin
                // y = round(acc), then acc = b1 * x
                cw.y_load  = 1'b1;
                cw.alu_a   = AA_PROD;
                cw.alu_b   = AB_ZERO;
                cw.alu_dst = DST_ACC;
            end
            3'd3:
            begin
                // prod = a1 * y
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_A1;
                cw.mul_src  = MS_Y;
            end
            3'd4:
            begin
                // acc = acc - prod
                cw.alu_a   = AA_ACC;
                cw.alu_b   = AB_PROD;
                cw.alu_op  = OP_SUB;
                cw.alu_dst = DST_ACC;
            end
            3'd5:
            begin
                // d1 = acc + d2, prod = b2 * x
                cw.alu_a    = AA_ACC;
                cw.alu_b    = AB_D2;
                cw.alu_dst  = DST_D1;
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_B2;
                cw.mul_src  = MS_X;
            end
            3'd6:
            begin
                // acc = b2 * x, prod = a2 * y
                cw.alu_a    = AA_PROD;
                cw.alu_b    = AB_ZERO;
                cw.alu_dst  = DST_ACC;
                cw.mul_en   = 1'b1;
                cw.coef_sel = COEF_A2;
                cw.mul_src  = MS_Y;
            end
            3'd7:
            begin
                // d2 = acc - prod, result out
                cw.alu_a   = AA_ACC;
                cw.alu_b   = AB_PROD;
                cw.alu_op  = OP_SUB;
                cw.alu_dst = DST_D2;
                cw.seq     = SQ_END;
            end
            default:
            begin
                cw = CW_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

[design/bqd_datapath.sv]
// Biquad datapath: shared multiplier, saturating adder, rounding stage and delay registers.
`default_nettype none

module bqd_datapath #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 26
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bqd_pkg::dp_ctrl_t            ctrl,
    input  wire logic [SAMPLE_WIDTH-1:0]      x_in,
    input  wire logic signed [COEF_WIDTH-1:0] coefs [bqd_pkg::NUM_REGS],
    output logic [SAMPLE_WIDTH-1:0]           y_out,
    output logic                              clip
);
    import bqd_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] Y_MAX =
        (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - 64'sd1;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [ACC_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        d1_reg;
    logic signed [ACC_W-1:0]        d2_reg;
    logic                           sat_reg;

    logic signed [COEF_WIDTH-1:0]              mul_a;
    logic signed [SAMPLE_WIDTH-1:0]            mul_b;
    logic signed [COEF_WIDTH+SAMPLE_WIDTH-1:0] mul_p;
    logic signed [ACC_W-1:0]                   prod_next;
    logic signed [ACC_W-1:0]                   alu_a;
    logic signed [ACC_W-1:0]                   alu_b;
    logic signed [ACC_W:0]                     alu_sum;
    logic                                      alu_ovf;
    logic signed [ACC_W-1:0]                   alu_res;
    logic signed [ACC_W-1:0]                   y_wide;
    logic signed [SAMPLE_WIDTH-1:0]            y_next;
    logic                                      y_clamp;
    logic                                      sat_now;

    always_comb
    begin
        mul_a     = coefs[ctrl.cw.coef_sel];
        mul_b     = (ctrl.cw.mul_src == MS_Y) ? y_reg : x_reg;
        mul_p     = (COEF_WIDTH+SAMPLE_WIDTH)'(mul_a) * (COEF_WIDTH+SAMPLE_WIDTH)'(mul_b);
        prod_next = ACC_W'(mul_p);

        alu_a = (ctrl.cw.alu_a == AA_ACC) ? acc_reg : prod_reg;
        case (ctrl.cw.alu_b)
            AB_ZERO: alu_b = '0;
            AB_D1:   alu_b = d1_reg;
            AB_D2:   alu_b = d2_reg;
            AB_PROD: alu_b = prod_reg;
            default: alu_b = '0;
        endcase
        if (ctrl.cw.alu_op == OP_SUB)
        begin
            alu_sum = {alu_a[ACC_W-1], alu_a} - {alu_b[ACC_W-1], alu_b};
        end
        else
        begin
            alu_sum = {alu_a[ACC_W-1], alu_a} + {alu_b[ACC_W-1], alu_b};
        end
        alu_ovf = alu_sum[ACC_W] != alu_sum[ACC_W-1];
        if (alu_ovf)
        begin
            alu_res = alu_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            alu_res = alu_sum[ACC_W-1:0];
        end

        // Round half up: floor of the shifted value plus the bit just below the cut.
        y_wide = (acc_reg >>> COEF_FRAC_BITS)
               + $signed({{(ACC_W-1){1'b0}}, acc_reg[COEF_FRAC_BITS-1]});
        y_clamp = 1'b0;
        if (y_wide > Y_MAX)
        begin
            y_next  = Y_MAX[SAMPLE_WIDTH-1:0];
            y_clamp = 1'b1;
        end
        else if (y_wide < Y_MIN)
        begin
            y_next  = Y_MIN[SAMPLE_WIDTH-1:0];
            y_clamp = 1'b1;
        end
        else
        begin
            y_next = y_wide[SAMPLE_WIDTH-1:0];
        end

        sat_now = ctrl.run
                && ((alu_ovf && (ctrl.cw.alu_dst != DST_NONE))
                    || (ctrl.cw.y_load && y_clamp));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg  <= '0;
            d2_reg  <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.start)
            begin
                sat_reg <= 1'b0;
            end
            else if (ctrl.run)
            begin
                sat_reg <= sat_reg | sat_now;
            end
            if (ctrl.run && (ctrl.cw.alu_dst == DST_D1))
            begin
                d1_reg <= alu_res;
            end
            if (ctrl.run && (ctrl.cw.alu_dst == DST_D2))
            begin
                d2_reg <= alu_res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            x_reg <= x_in;
        end
        if (ctrl.run && ctrl.cw.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.run && (ctrl.cw.alu_dst == DST_ACC))
        begin
            acc_reg <= alu_res;
        end
        if (ctrl.run && ctrl.cw.y_load)
        begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;
    assign clip  = sat_reg | sat_now;

endmodule

`default_nettype wire

[design/biquad_iir_filter.sv]
// Top level of the biquad IIR section: stream ports, coefficient registers and microcode sequencer.
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: sample_in
// m_*       out        m_tvalid/m_tready  m_tdata: sample_out, m_tuser: clipped
// APB       in/out     psel/penable       coef_b0, coef_b1, coef_b2, coef_a1, coef_a2
//
// Each sample runs an eight-step microprogram that shares one multiplier across the
// five products, so the block takes no new sample until the last one is through;
// the next sample is accepted in the same cycle that the previous program finishes.
// Reset loads b0 = 1.0 and zeros the other coefficients and both delay registers.
// One output register holds a finished result; if it has not been taken, the
// program holds at its last step and the input side waits.

module biquad_iir_filter #(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int COEF_WIDTH     = 32,
    parameter int COEF_FRAC_BITS = 26
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  s_tdata,   // sample_in, zero padding
    // Output stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_tdata,   // sample_out, zero padding
    output logic                                    m_tuser,   // clipped
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [4:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import bqd_pkg::*;

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam logic [63:0] ONE_WIDE = 64'd1 << COEF_FRAC_BITS;
    localparam logic signed [COEF_WIDTH-1:0] B0_RESET = ONE_WIDE[COEF_WIDTH-1:0];

    logic signed [COEF_WIDTH-1:0] coef_reg [NUM_REGS];
    logic                         cfg_write;

    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [SAMPLE_WIDTH-1:0] out_sample_reg;
    logic                    out_clip_reg;

    ctrl_word_t              cw;
    dp_ctrl_t                dp_ctrl;
    logic                    finish;
    logic                    accept;
    logic [SAMPLE_WIDTH-1:0] y_val;
    logic                    clip_val;

    // ------------------------------------------------------------------
    // Configuration registers. Writes to addresses past the last
    // coefficient are dropped; reads there return zero.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[COEF_B0] <= B0_RESET;
            coef_reg[COEF_B1] <= '0;
            coef_reg[COEF_B2] <= '0;
            coef_reg[COEF_A1] <= '0;
            coef_reg[COEF_A2] <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                COEF_B0: coef_reg[COEF_B0] <= pwdata[COEF_WIDTH-1:0];
                COEF_B1: coef_reg[COEF_B1] <= pwdata[COEF_WIDTH-1:0];
                COEF_B2: coef_reg[COEF_B2] <= pwdata[COEF_WIDTH-1:0];
                COEF_A1: coef_reg[COEF_A1] <= pwdata[COEF_WIDTH-1:0];
                COEF_A2: coef_reg[COEF_A2] <= pwdata[COEF_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            COEF_B0: prdata = 32'(coef_reg[COEF_B0]);
            COEF_B1: prdata = 32'(coef_reg[COEF_B1]);
            COEF_B2: prdata = 32'(coef_reg[COEF_B2]);
            COEF_A1: prdata = 32'(coef_reg[COEF_A1]);
            COEF_A2: prdata = 32'(coef_reg[COEF_A2]);
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer. The step counter addresses the control ROM; the last
    // step jumps back to step zero only when the output register is free
    // (empty, or emptied by a transfer in this cycle).
    // ------------------------------------------------------------------
    always_comb
    begin
        cw       = ucode(step_reg);
        finish   = busy_reg && (cw.seq == SQ_END) && (!out_valid_reg || m_tready);
        s_tready = !busy_reg || finish;
        accept   = s_tvalid && s_tready;

        dp_ctrl.cw    = cw;
        dp_ctrl.run   = busy_reg && ((cw.seq != SQ_END) || finish);
        dp_ctrl.start = accept;

        busy_next = busy_reg;
        step_next = step_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
            step_next = '0;
        end
        else if (dp_ctrl.run)
        begin
            step_next = step_reg + STEP_W'(1);
        end

        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result is captured as the last step executes, so the clip flag
    // includes that step's own saturation.
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_sample_reg <= y_val;
            out_clip_reg   <= clip_val;
        end
    end

    bqd_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_WIDTH     (COEF_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dp_ctrl),
        .x_in  (s_tdata[SAMPLE_WIDTH-1:0]),
        .coefs (coef_reg),
        .y_out (y_val),
        .clip  (clip_val)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_sample_reg);
    assign m_tuser  = out_clip_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A finished program always leaves a result in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) finish |=> out_valid_reg)
        else $error("program finished without a pending result");

    // The step counter rests at zero while no sample is in flight.
    assert property (@(posedge clk) disable iff (!rst_n) !busy_reg |-> (step_reg == '0))
        else $error("step counter moved while idle");

    // An accepted sample starts the program at its first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (busy_reg && (step_reg == '0)))
        else $error("accepted sample did not start the program");

    // Before the last step the counter advances by one step per cycle; only the last step can hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (cw.seq == SQ_NEXT)) |=> (step_reg == $past(step_reg) + STEP_W'(1)))
        else $error("step counter skipped or stalled mid-program");

endmodule

`default_nettype wire
